/* rtl/core/fhr_pkg.sv */
// Package: constants, types and twiddle function for the heart-rate FFT core.
`default_nettype none
package fhr_pkg;
  localparam int Points = 2048;
  localparam int LogPoints = 11;
  localparam int AddrW = LogPoints;
  localparam int StageW = 4;
  localparam int BinLimit = 2048;
  localparam int ReW = 32;
  localparam longint unsigned PiQ30 = 64'd3373259426;
  localparam longint unsigned OneQ30 = 64'd1073741824;

  localparam logic [1:0] CfgLow  = 2'd0;
  localparam logic [1:0] CfgHigh = 2'd1;
  localparam logic [1:0] CfgRate = 2'd2;

  typedef enum logic [2:0] {
    ST_FILL, ST_REV, ST_BFLY, ST_START, ST_SCAN, ST_BPM, ST_OUT
  } fhr_state_t;

  typedef struct packed {
    logic               write_sample;
    logic               rev_step;
    logic               bfly_step;
    logic               scan_step;
    logic               scan_start;
    logic               bpm_step;
    logic               clear;
  } fhr_cmd_t;

  typedef struct packed {
    logic fill_done;
    logic rev_done;
    logic bfly_done;
    logic scan_done;
    logic bpm_done;
  } fhr_status_t;

  function automatic logic [15:0] q15(input longint signed v);
    longint unsigned r;
    begin
      r = (v < 0) ? 64'd0 : ((64'(v) + 64'd16384) >> 15);
      if (r > 64'd32767) r = 64'd32767;
      q15 = r[15:0];
    end
  endfunction

  // cos and sin of pi*m/(Points/2), m in first octant; Taylor series in Q30
  function automatic logic [31:0] octant_cs(input int unsigned m);
    longint unsigned x, x2, ts, tc;
    longint signed as_, ac;
    begin
      x = (PiQ30 * 64'(m)) / 64'(Points / 2);
      x2 = (x * x) >> 30;
      ts = x; tc = OneQ30;
      as_ = longint'(x); ac = longint'(OneQ30);
      for (int n = 1; n <= 9; n++) begin
        ts = ((ts * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        tc = ((tc * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
        if (n % 2 == 1) begin
          as_ -= longint'(ts); ac -= longint'(tc);
        end else begin
          as_ += longint'(ts); ac += longint'(tc);
        end
      end
      octant_cs = {q15(ac), q15(as_)};
    end
  endfunction

  // {cos, sin} for m in [0, Points/2), each Q1.15 signed
  function automatic logic [31:0] twiddle(input int unsigned m);
    logic [31:0] q;
    logic [31:0] r;
    int unsigned mm;
    begin
      mm = (m <= Points / 4) ? m : m - Points / 4;
      if (mm <= Points / 8) q = octant_cs(mm);
      else begin
        r = octant_cs(Points / 4 - mm);
        q = {r[15:0], r[31:16]};
      end
      if (m <= Points / 4) twiddle = q;
      else twiddle = {16'(-$signed(q[15:0])), q[31:16]};
    end
  endfunction
endpackage
`default_nettype wire

/* rtl/core/fhr_stream_if.sv */
// Valid/ready channel interface carrying a generic payload.
`default_nettype none
interface fhr_stream_if #(parameter int W = 16);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/fhr_twiddle_rom.sv */
// Registered twiddle table, Q1.15 cos and sin.
`default_nettype none
module fhr_twiddle_rom (
  input  wire logic                        clk,
  input  wire logic [fhr_pkg::AddrW-2:0]   addr,
  output logic [31:0]                      cs
);
  import fhr_pkg::*;
  logic [31:0] rom [Points/2];
  always_comb begin
    for (int i = 0; i < Points / 2; i++) rom[i] = twiddle(i);
  end
  always_ff @(posedge clk) cs <= rom[addr];
endmodule
`default_nettype wire

/* rtl/core/fhr_datapath.sv */
// Datapath: sample memory, bit-reverse pass, butterfly unit, power scan, bpm.
`default_nettype none
module fhr_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire fhr_pkg::fhr_cmd_t    cmd,
  output fhr_pkg::fhr_status_t      sts,
  input  wire logic [15:0]          sample,
  input  wire logic [10:0]          low_bin,
  input  wire logic [11:0]          high_bin,
  input  wire logic [9:0]           sample_rate_hz,
  output logic [10:0]               peak_bin,
  output logic [15:0]               heart_rate_bpm
);
  import fhr_pkg::*;

  logic [2*ReW-1:0] mem [Points];
  logic [AddrW:0]   cnt;        // sample / bin / reverse counter
  logic [2:0]       ph;         // phase inside one multi-cycle step
  logic [StageW-1:0] stage;
  logic [AddrW-2:0] bidx;       // butterfly index within stage
  logic [2*ReW-1:0] ra, rb;
  logic [AddrW-1:0] aa, ab;
  logic [31:0]      cs;
  logic [AddrW-2:0] twa;
  logic signed [ReW-1:0] br, bi, ar, ai;
  logic signed [47:0] p0, p1, p2, p3;
  logic signed [ReW:0] tr, ti;
  logic [63:0] best, pw;
  logic [63:0] sq0, sq1;
  logic [10:0] peak;
  logic [11:0] scan_end;
  logic [31:0] prod;

  function automatic logic [AddrW-1:0] brev(input logic [AddrW-1:0] v);
    for (int b = 0; b < AddrW; b++) brev[b] = v[AddrW-1-b];
  endfunction

  // butterfly addresses: insert a zero/one at bit 'stage'
  logic [AddrW-1:0] lowmask;
  always_comb begin
    lowmask = AddrW'((1 << stage) - 1);
    aa = ((AddrW'(bidx) & ~lowmask) << 1) | (AddrW'(bidx) & lowmask);
    ab = aa | AddrW'(1 << stage);
    twa = (AddrW-1)'(AddrW'(bidx & lowmask[AddrW-2:0]) << (LogPoints - 1 - stage));
  end

  fhr_twiddle_rom u_rom (.clk(clk), .addr(twa), .cs(cs));

  assign scan_end = (high_bin > 12'(BinLimit)) ? 12'(BinLimit) : high_bin;
  assign sts.fill_done = (cnt == (AddrW+1)'(Points - 1));
  assign sts.rev_done  = (cnt == (AddrW+1)'(Points - 1)) && ph == 3'd3;
  assign sts.bfly_done = (stage == StageW'(LogPoints - 1)) && (&bidx) && ph == 3'd5;
  assign sts.scan_done = ph == 3'd3 && ({1'b0, cnt} + 13'd1 >= {1'b0, scan_end});
  assign sts.bpm_done  = ph == 3'd1;

  assign ar = ra[63:32]; assign ai = ra[31:0];
  assign br = rb[63:32]; assign bi = rb[31:0];

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      cnt <= '0; ph <= '0; stage <= '0; bidx <= '0;
    end else if (cmd.write_sample) begin
      mem[cnt[AddrW-1:0]] <= {16'd0, sample, 32'd0};
      cnt <= sts.fill_done ? '0 : cnt + 1'b1;
    end else if (cmd.rev_step) begin
      // read pair, write swapped
      unique case (ph)
        3'd0: begin ra <= mem[cnt[AddrW-1:0]]; ph <= 3'd1; end
        3'd1: begin rb <= mem[brev(cnt[AddrW-1:0])]; ph <= 3'd2; end
        3'd2: begin
          if (brev(cnt[AddrW-1:0]) > cnt[AddrW-1:0]) mem[cnt[AddrW-1:0]] <= rb;
          ph <= 3'd3;
        end
        default: begin
          if (brev(cnt[AddrW-1:0]) > cnt[AddrW-1:0]) mem[brev(cnt[AddrW-1:0])] <= ra;
          ph <= '0;
          cnt <= sts.rev_done ? '0 : cnt + 1'b1;
        end
      endcase
    end else if (cmd.bfly_step) begin
      unique case (ph)
        3'd0: begin ra <= mem[aa]; ph <= 3'd1; end
        3'd1: begin rb <= mem[ab]; ph <= 3'd2; end
        3'd2: begin
          p0 <= $signed(cs[31:16]) * br; p1 <= $signed(cs[15:0]) * bi;
          p2 <= $signed(cs[31:16]) * bi; p3 <= $signed(cs[15:0]) * br;
          ph <= 3'd3;
        end
        3'd3: begin
          tr <= (ReW+1)'((64'(p0) + 64'(p1) + 64'sd16384) >>> 15);
          ti <= (ReW+1)'((64'(p2) - 64'(p3) + 64'sd16384) >>> 15);
          ph <= 3'd4;
        end
        3'd4: begin
          mem[aa] <= {ReW'(($signed({ar[ReW-1], ar}) + tr) >>> 1),
                      ReW'(($signed({ai[ReW-1], ai}) + ti) >>> 1)};
          ph <= 3'd5;
        end
        default: begin
          mem[ab] <= {ReW'(($signed({ar[ReW-1], ar}) - tr) >>> 1),
                      ReW'(($signed({ai[ReW-1], ai}) - ti) >>> 1)};
          ph <= '0;
          bidx <= bidx + 1'b1;
          if (&bidx) stage <= stage + 1'b1;
        end
      endcase
    end else if (cmd.scan_start) begin
      cnt <= {1'b0, low_bin}; ph <= '0; peak <= low_bin;
    end else if (cmd.scan_step) begin
      unique case (ph)
        3'd0: begin ra <= mem[cnt[AddrW-1:0]]; ph <= 3'd1; end
        3'd1: begin
          sq0 <= 64'($signed(ar) * $signed(ar)); sq1 <= 64'($signed(ai) * $signed(ai));
          ph <= 3'd2;
        end
        3'd2: begin pw <= sq0 + sq1; ph <= 3'd3; end
        default: begin
          if (cnt == {1'b0, low_bin} || pw > best) begin
            best <= pw; peak <= cnt[10:0];
          end
          cnt <= cnt + 1'b1; ph <= '0;
        end
      endcase
    end else if (cmd.bpm_step) begin
      if (ph == 3'd0) begin
        prod <= 32'(peak) * 32'(sample_rate_hz) * 32'd60;
        ph <= 3'd1;
      end else begin
        peak_bin <= peak;
        heart_rate_bpm <= ((prod >> LogPoints) > 32'd65535) ? 16'hFFFF
                          : 16'(prod >> LogPoints);
        ph <= '0;
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/core/fhr_ctrl.sv */
// Controller state machine sequencing fill, FFT, scan and output.
`default_nettype none
module fhr_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire logic                 scan_empty,
  input  wire fhr_pkg::fhr_status_t sts,
  output fhr_pkg::fhr_cmd_t         cmd
);
  import fhr_pkg::*;
  fhr_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_FILL;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_FILL: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.write_sample = 1'b1;
          if (sts.fill_done) state_next = ST_REV;
        end
      end
      ST_REV: begin
        cmd.rev_step = 1'b1;
        if (sts.rev_done) state_next = ST_BFLY;
      end
      ST_BFLY: begin
        cmd.bfly_step = 1'b1;
        if (sts.bfly_done) begin
          state_next = ST_START;
        end
      end
      // load the first bin; an empty range goes straight to bpm
      ST_START: begin
        cmd.scan_start = 1'b1;
        if (scan_empty) state_next = ST_BPM;
        else state_next = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_next = ST_BPM;
      end
      ST_BPM: begin
        cmd.bpm_step = 1'b1;
        if (sts.bpm_done) state_next = ST_OUT;
      end
      default: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.clear = 1'b1; state_next = ST_FILL;
        end
      end
    endcase
  end
endmodule
`default_nettype wire

/* rtl/core/fft_heart_rate_peak_estimator_core.sv */
// Top level: frame buffer FFT heart-rate peak estimator.
// Accepts one sample per cycle while filling a 2048-sample frame, none while processing.
// After the last sample: a bit-reverse pass, 11x1024 butterflies, a scan set-up, a power
// scan over each searched bin and a bpm step; the result is then offered on out_ch.
// The default search range covers 102 bins; up to 2048 bins can be searched.
// Synchronous reset sets registers to 20/122/50 and empties the frame.
`default_nettype none
module fft_heart_rate_peak_estimator_core (
  input  wire logic       clk,
  input  wire logic       rst,
  fhr_stream_if.sink      in_ch,
  fhr_stream_if.source    out_ch,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [11:0] cfg_data
);
  import fhr_pkg::*;
  fhr_cmd_t    cmd;
  fhr_status_t sts;
  logic [10:0] low_bin;
  logic [11:0] high_bin;
  logic [9:0]  sample_rate_hz;
  logic [10:0] peak_bin;
  logic [15:0] heart_rate_bpm;
  logic        scan_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      low_bin <= 11'd20; high_bin <= 12'd122; sample_rate_hz <= 10'd50;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgLow:  low_bin <= cfg_data[10:0];
        CfgHigh: high_bin <= cfg_data;
        CfgRate: sample_rate_hz <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  assign scan_empty = {1'b0, low_bin} >=
                      ((high_bin > 12'(BinLimit)) ? 12'(BinLimit) : high_bin);

  fhr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .scan_empty(scan_empty),
    .sts(sts), .cmd(cmd)
  );

  fhr_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .sample(in_ch.data),
    .low_bin(low_bin), .high_bin(high_bin), .sample_rate_hz(sample_rate_hz),
    .peak_bin(peak_bin), .heart_rate_bpm(heart_rate_bpm)
  );

  assign out_ch.data = {peak_bin, heart_rate_bpm};

  a_no_both: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid)) else $error("input and output open together");
  a_out_clears: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.ready |=> in_ch.ready) else $error("no refill after transfer");
endmodule
`default_nettype wire
